@@ rtl/core/crcfp_pkg.sv @@
// Package of the CRC16 framed packet parser: types, constants and the CRC table.
package crcfp_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;

  // Frame layout.
  localparam int unsigned FRAME_OVERHEAD = 9;
  localparam logic [7:0]  POS_LENGTH     = 8'd2;
  localparam logic [7:0]  POS_KIND       = 8'd3;
  localparam logic [7:0]  POS_DATA_LEN   = 8'd4;
  localparam logic [7:0]  PAYLOAD_START  = 8'd5;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_FIELDS,
    ST_BODY,
    ST_EMIT
  } ctl_state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HUNT,
    OP_FIELD,
    OP_BODY
  } op_e;

  typedef struct packed {
    op_e  op;          // how the accepted byte is processed
    logic emit_start;  // rewind the read-out pointer
    logic emit_en;     // read-out of the payload store is running
  } cmd_t;

  typedef struct packed {
    logic hdr_hit;      // second header byte matches a valid first byte
    logic fields_done;  // current byte is the payload length byte
    logic len_ok;       // frame length checks pass
    logic frame_end;    // current byte is the last of the frame
    logic crc_ok;       // received CRC matched
    logic emit_done;    // last result of the frame loaded
  } sts_t;

  localparam logic [15:0] CRC_TABLE [256] = '{
    16'h2ae2, 16'hf965, 16'ha429, 16'h1b33, 16'hd0ce, 16'hd13a, 16'h69c2, 16'he829,
    16'ha785, 16'hbec6, 16'he141, 16'h3093, 16'hb528, 16'h94d3, 16'hdfb9, 16'h5c62,
    16'h98c2, 16'h6fad, 16'h234b, 16'h8f03, 16'hba66, 16'h1ebb, 16'h2060, 16'hb68e,
    16'h68c9, 16'ha3b5, 16'hbceb, 16'h17dc, 16'h7b28, 16'h63ba, 16'h91aa, 16'ha60b,
    16'h5d20, 16'h35d4, 16'hc13e, 16'h2def, 16'h870e, 16'h2b01, 16'h9618, 16'hae94,
    16'h69c7, 16'h775a, 16'hdf27, 16'h1ef1, 16'h0c2e, 16'h3ee1, 16'hfb52, 16'h24f0,
    16'hae8e, 16'h1e9e, 16'h33f3, 16'he8f4, 16'hbd58, 16'hd452, 16'h1f83, 16'h2622,
    16'h7808, 16'h5c6f, 16'h3dfe, 16'h7331, 16'hc029, 16'h4fa8, 16'h193d, 16'h1d4a,
    16'h057d, 16'hda7b, 16'hcb38, 16'h8c8b, 16'h857d, 16'h6151, 16'h3b20, 16'h6f44,
    16'h58ab, 16'h9a47, 16'h8e35, 16'he4d9, 16'h5928, 16'h0988, 16'h09ca, 16'h87b6,
    16'ha825, 16'hbdbd, 16'h70ab, 16'h657e, 16'h9210, 16'h102f, 16'h0ba1, 16'h8a19,
    16'h6c9e, 16'hc99e, 16'hfd4a, 16'h2cc8, 16'h1948, 16'h9687, 16'hca11, 16'h1ec5,
    16'hf102, 16'h954a, 16'h2b50, 16'h7680, 16'h769b, 16'he670, 16'he5c5, 16'hcf46,
    16'h00b8, 16'hf3fa, 16'h3420, 16'h59e1, 16'h7d83, 16'hbdea, 16'he197, 16'h25a9,
    16'h7ba8, 16'hd243, 16'h8b28, 16'h8db8, 16'he272, 16'h96c9, 16'h17d2, 16'h4f11,
    16'he067, 16'h951c, 16'h7bd9, 16'hf9af, 16'h2ba4, 16'h45eb, 16'h9874, 16'h9ca7,
    16'h5b35, 16'hc3c5, 16'h9327, 16'h51d0, 16'h2a36, 16'h78ed, 16'h2117, 16'h2aee,
    16'hece8, 16'hd537, 16'h84cf, 16'hea6b, 16'h9322, 16'he667, 16'h1015, 16'h0ecb,
    16'hb8ab, 16'h9b3d, 16'h9c83, 16'h9b1e, 16'hb206, 16'h3456, 16'hea2f, 16'h126f,
    16'h4972, 16'he608, 16'h0c1f, 16'hf516, 16'habf3, 16'h2494, 16'h91be, 16'h0729,
    16'h6859, 16'h24e6, 16'hd8f8, 16'h928f, 16'h1dd4, 16'h7a0f, 16'hbd7d, 16'h8abc,
    16'h4f47, 16'hc24d, 16'h7528, 16'he269, 16'h28b5, 16'h853d, 16'hf134, 16'he160,
    16'ha07b, 16'h0db9, 16'h7c7f, 16'hd281, 16'hc20e, 16'he6ae, 16'he4f0, 16'h0b81,
    16'hccb7, 16'h7110, 16'h0098, 16'hf8aa, 16'h95a4, 16'h1256, 16'h7fd3, 16'hfdfd,
    16'h373d, 16'h58cc, 16'h908d, 16'hd510, 16'hd2db, 16'hce0a, 16'h5fcd, 16'h2224,
    16'h1058, 16'hd4f5, 16'h048e, 16'h390d, 16'hda32, 16'h75c3, 16'h9a6d, 16'hfaad,
    16'h837c, 16'h16ed, 16'hcd30, 16'hc58a, 16'h7d9b, 16'h3221, 16'hd10b, 16'hca52,
    16'ha331, 16'h51a4, 16'hc2fd, 16'h38d6, 16'he3f9, 16'h42d1, 16'hb6d3, 16'h1b37,
    16'h9b9d, 16'hc760, 16'h7047, 16'h6e7a, 16'h956c, 16'hd014, 16'h109e, 16'h25c4,
    16'h250a, 16'h952b, 16'hded1, 16'h7f3d, 16'h0aef, 16'h793f, 16'h79eb, 16'h0e6b,
    16'h902d, 16'hc71b, 16'hd3f5, 16'h8dc8, 16'hf93d, 16'h2502, 16'h581c, 16'h9c6f,
    16'hf6a5, 16'h1b1a, 16'h5546, 16'hda9f, 16'h5dec, 16'h8c19, 16'h75d7, 16'h7989
  };

  // One byte step of the table-driven CRC.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0] idx;
    idx = crc[15:8] ^ data;
    return CRC_TABLE[idx] ^ {crc[7:0], 8'h00};
  endfunction

endpackage

@@ rtl/core/crcfp_ctrl.sv @@
// Controller of the packet parser: frame phase and payload read-out sequencing.
module crcfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  input  crcfp_pkg::sts_t   sts_i,
  output crcfp_pkg::cmd_t   cmd_o
);

  crcfp_pkg::ctl_state_e state_q, state_d;
  logic                  accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crcfp_pkg::ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    rx_stall_o      = 1'b0;
    cmd_o.op        = crcfp_pkg::OP_NONE;
    cmd_o.emit_start = 1'b0;
    cmd_o.emit_en   = 1'b0;
    accept          = rx_valid_i;
    case (state_q)
      crcfp_pkg::ST_HUNT: begin
        if (accept) begin
          cmd_o.op = crcfp_pkg::OP_HUNT;
          if (sts_i.hdr_hit) state_d = crcfp_pkg::ST_FIELDS;
        end
      end
      crcfp_pkg::ST_FIELDS: begin
        if (accept) begin
          cmd_o.op = crcfp_pkg::OP_FIELD;
          if (sts_i.fields_done) begin
            state_d = sts_i.len_ok ? crcfp_pkg::ST_BODY : crcfp_pkg::ST_HUNT;
          end
        end
      end
      crcfp_pkg::ST_BODY: begin
        if (accept) begin
          cmd_o.op = crcfp_pkg::OP_BODY;
          if (sts_i.frame_end) begin
            if (sts_i.crc_ok) begin
              cmd_o.emit_start = 1'b1;
              state_d          = crcfp_pkg::ST_EMIT;
            end else begin
              state_d = crcfp_pkg::ST_HUNT;
            end
          end
        end
      end
      crcfp_pkg::ST_EMIT: begin
        // The store has a single read port, so input waits during read-out.
        rx_stall_o    = 1'b1;
        accept        = 1'b0;
        cmd_o.emit_en = 1'b1;
        if (sts_i.emit_done) state_d = crcfp_pkg::ST_HUNT;
      end
      default: begin
        state_d = crcfp_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

@@ rtl/core/crcfp_dp.sv @@
// Datapath of the packet parser: header match, field capture, CRC, payload store, output register.
module crcfp_dp #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crcfp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic [7:0]                        rx_byte_i,
  input  crcfp_pkg::cmd_t                   cmd_i,
  output crcfp_pkg::sts_t                   sts_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [7:0]                        payload_byte_o,
  output logic [5:0]                        byte_offset_o,
  output logic [5:0]                        payload_length_o,
  output logic [7:0]                        frame_kind_o,
  output logic                              last_o
);

  localparam int unsigned StoreDepth = (MAX_FRAME > crcfp_pkg::FRAME_OVERHEAD) ?
                                       MAX_FRAME - crcfp_pkg::FRAME_OVERHEAD : 1;
  localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [8:0]  MaxLen     = 9'(MAX_FRAME);
  localparam logic [8:0]  Overhead   = 9'(crcfp_pkg::FRAME_OVERHEAD);

  logic [7:0]  hdr_first_q, hdr_second_q;
  logic [7:0]  byte_count_q, first_seen_q, frame_len_q, kind_q, pay_len_q, crc_high_q;
  logic [15:0] crc_q;
  logic [7:0]  rd_idx_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_kind_q;
  logic [5:0]  out_offset_q, out_len_q;
  logic        out_empty_q, out_last_q;
  logic [7:0]  mem_q [StoreDepth];

  logic [7:0]       count_inc, pay_end, wr_off, rd_next;
  logic [15:0]      crc_next, crc_first;
  logic             in_payload, is_crc_hi, is_crc_lo;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic             out_take, load, load_last;

  assign count_inc  = byte_count_q + 8'd1;
  assign crc_next   = crcfp_pkg::crc_fold(crc_q, rx_byte_i);
  // CRC after the first header byte alone, starting from zero.
  assign crc_first  = crcfp_pkg::CRC_TABLE[rx_byte_i];
  assign pay_end    = pay_len_q + crcfp_pkg::PAYLOAD_START;
  assign in_payload = byte_count_q < pay_end;
  assign is_crc_hi  = byte_count_q == pay_end;
  assign is_crc_lo  = byte_count_q == pay_end + 8'd1;
  assign wr_off     = byte_count_q - crcfp_pkg::PAYLOAD_START;
  assign wr_addr    = wr_off[AddrW-1:0];
  assign rd_addr    = rd_idx_q[AddrW-1:0];
  assign rd_next    = rd_idx_q + 8'd1;

  assign out_take  = out_valid_q & ~out_stall_i;
  assign load      = cmd_i.emit_en & (~out_valid_q | out_take);
  assign load_last = (pay_len_q == 8'd0) | (rd_next == pay_len_q);

  assign sts_o.hdr_hit     = (byte_count_q == 8'd1) && (first_seen_q == hdr_first_q) &&
                             (rx_byte_i == hdr_second_q);
  assign sts_o.fields_done = byte_count_q == crcfp_pkg::POS_DATA_LEN;
  assign sts_o.len_ok      = ({1'b0, frame_len_q} <= MaxLen) && ({1'b0, frame_len_q} >= Overhead) &&
                             ({1'b0, frame_len_q} == {1'b0, rx_byte_i} + Overhead);
  assign sts_o.frame_end   = count_inc == frame_len_q;
  // The last byte is footer, so the CRC is already final here.
  assign sts_o.crc_ok      = crc_q == 16'h0000;
  assign sts_o.emit_done   = load & load_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= '0;
      hdr_second_q <= '0;
      byte_count_q <= '0;
      first_seen_q <= '0;
      frame_len_q  <= '0;
      kind_q       <= '0;
      pay_len_q    <= '0;
      crc_q        <= '0;
      crc_high_q   <= '0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          crcfp_pkg::CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i;
          crcfp_pkg::CFG_HEADER_SECOND: hdr_second_q <= cfg_data_i;
          default: ;
        endcase
      end

      case (cmd_i.op)
        crcfp_pkg::OP_HUNT: begin
          if (byte_count_q == 8'd0) begin
            first_seen_q <= rx_byte_i;
            crc_q        <= crc_first;
            byte_count_q <= 8'd1;
          end else if (sts_o.hdr_hit) begin
            crc_q        <= crc_next;
            byte_count_q <= 8'd2;
          end else if (rx_byte_i == hdr_first_q) begin
            // Resynchronize on a repeated first header byte.
            first_seen_q <= rx_byte_i;
            crc_q        <= crc_first;
            byte_count_q <= 8'd1;
          end else begin
            byte_count_q <= 8'd0;
          end
        end
        crcfp_pkg::OP_FIELD: begin
          byte_count_q <= count_inc;
          crc_q        <= crc_next;
          if (byte_count_q == crcfp_pkg::POS_LENGTH) begin
            frame_len_q <= rx_byte_i;
          end else if (byte_count_q == crcfp_pkg::POS_KIND) begin
            kind_q <= rx_byte_i;
          end else begin
            pay_len_q <= rx_byte_i;
            if (!sts_o.len_ok) byte_count_q <= 8'd0;
          end
        end
        crcfp_pkg::OP_BODY: begin
          byte_count_q <= sts_o.frame_end ? 8'd0 : count_inc;
          if (in_payload) begin
            crc_q <= crc_next;
          end else if (is_crc_hi) begin
            crc_high_q <= rx_byte_i;
          end else if (is_crc_lo) begin
            crc_q <= crc_q ^ {crc_high_q, rx_byte_i};
          end
        end
        default: ;
      endcase

      if (cmd_i.emit_start) begin
        rd_idx_q <= 8'd0;
      end else if (load) begin
        rd_idx_q <= rd_next;
      end

      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == crcfp_pkg::OP_BODY && in_payload) begin
      mem_q[wr_addr] <= rx_byte_i;
    end
    if (load) begin
      out_byte_q   <= mem_q[rd_addr];
      out_offset_q <= rd_idx_q[5:0];
      out_len_q    <= pay_len_q[5:0];
      out_kind_q   <= kind_q;
      out_empty_q  <= pay_len_q == 8'd0;
      out_last_q   <= load_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = out_empty_q ? 8'h00 : out_byte_q;
  assign byte_offset_o    = out_offset_q;
  assign payload_length_o = out_len_q;
  assign frame_kind_o     = out_kind_q;
  assign last_o           = out_last_q;

endmodule

@@ rtl/core/crc16_framed_packet_parser_top.sv @@
// Top level of the CRC16 framed packet parser.
//
//   Channel   Direction  Handshake               Beat contents
//   rx        in         rx_valid_i / rx_stall_o  rx_byte_i
//   out       out        out_valid_o / out_stall_i payload_byte_o, byte_offset_o,
//                                                  payload_length_o, frame_kind_o, last_o
//   cfg       in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Received bytes are taken one per cycle while a frame is being parsed.
// After a frame with a good CRC the input stalls while the payload store is read
// out through its single read port, one payload byte per output beat (a single beat
// for an empty payload); the read-out also waits while the output side stalls.
// Reset clears the control state and header registers; the payload store needs no clearing pass.
module crc16_framed_packet_parser_top #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [crcfp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                      cfg_data_i,
  input  logic                            rx_valid_i,
  output logic                            rx_stall_o,
  input  logic [7:0]                      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      payload_byte_o,
  output logic [5:0]                      byte_offset_o,
  output logic [5:0]                      payload_length_o,
  output logic [7:0]                      frame_kind_o,
  output logic                            last_o
);

  crcfp_pkg::cmd_t cmd;
  crcfp_pkg::sts_t sts;

  crcfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crcfp_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .payload_byte_o   (payload_byte_o),
    .byte_offset_o    (byte_offset_o),
    .payload_length_o (payload_length_o),
    .frame_kind_o     (frame_kind_o),
    .last_o           (last_o)
  );

`ifndef SYNTH
  // A good frame always starts a read-out, which holds off the input.
  a_emit_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_start |=> rx_stall_o)
    else $error("read-out started without stalling input");

  // The read-out can only finish while it is running.
  a_done_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.emit_done |-> cmd.emit_en)
    else $error("read-out finished outside read-out");

  // The final beat of a nonempty payload carries the last offset.
  a_last_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && payload_length_o != 6'd0) |->
      (byte_offset_o == payload_length_o - 6'd1))
    else $error("last beat at wrong offset");
`endif

endmodule
